### hw/rtl/vcfgt_pkg.sv
package vcfgt_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [8:0] VALUE_CAP = 9'd256;
  localparam logic [8:0] MAX_INDEX = 9'd254;
  localparam logic [2:0] LEN_MAX   = 3'd7;
  localparam logic [1:0] SEP_MAX   = 2'd3;

  typedef enum logic [3:0] {
    PH_WS     = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       neg;
    logic       digits;
    logic       start;
    logic       dot;
    logic [8:0] value;
  } side_t;

  typedef struct packed {
    logic [2:0]      gt_length;
    logic [1:0]      sep_count;
    logic [7:0]      head0;
    logic            head1_sep;
    logic [7:0]      head2;
    side_t [1:0]     side;
  } snap_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_EMPTY       = 4'd1,
    ST_BAD_HAPLOID = 4'd2,
    ST_BAD_FIRST   = 4'd3,
    ST_BAD_SECOND  = 4'd4,
    ST_POLYPLOID   = 4'd5,
    ST_NEG_HAPLOID = 4'd6,
    ST_EDGE        = 4'd7,
    ST_NEG_FIRST   = 4'd8,
    ST_NEG_SECOND  = 4'd9,
    ST_NO_DIGITS   = 4'd10,
    ST_TOO_LARGE   = 4'd11
  } status_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_PIPE);
  endfunction

endpackage

### hw/rtl/vcfgt_if.sv
interface vcfgt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       field_end;

  modport source(output valid, output char_in, output field_end, input ready);
  modport sink(input valid, input char_in, input field_end, output ready);
endinterface

interface vcfgt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] ploidy;
  logic [7:0] first_allele;
  logic [7:0] second_allele;
  logic [3:0] status;

  modport source(output valid, output ploidy, output first_allele,
                 output second_allele, output status, input ready);
  modport sink(input valid, input ploidy, input first_allele,
               input second_allele, input status, output ready);
endinterface

### hw/rtl/vcfgt_scan.sv
module vcfgt_scan (
  input  logic             clk,
  input  logic             rst_n,
  vcfgt_in_if.sink         in_ch,
  input  logic             out_free,
  output vcfgt_pkg::snap_t snap,
  output logic             snap_valid
);

  vcfgt_pkg::snap_t live_r, live_nxt, clear_val;
  vcfgt_pkg::snap_t snap_r;
  logic             colon_r, colon_nxt;
  logic             snap_v_r, snap_v_nxt;
  logic             accept;
  logic [7:0]       c;

  function automatic logic is_space(logic [7:0] ch);
    return (ch == vcfgt_pkg::CH_SPACE) || ((ch >= vcfgt_pkg::CH_TAB) && (ch <= vcfgt_pkg::CH_CR));
  endfunction

  function automatic vcfgt_pkg::side_t feed(vcfgt_pkg::side_t s_in, logic [7:0] ch);
    vcfgt_pkg::side_t s;
    logic [11:0]      v;
    s = s_in;
    v = ({3'b000, s_in.value} << 3) + ({3'b000, s_in.value} << 1) + {8'h00, ch[3:0]};
    if (!s_in.start) begin
      s.start = 1'b1;
      s.dot   = (ch == vcfgt_pkg::CH_DOT);
    end else begin
      s.dot = 1'b0;
    end
    if (s_in.phase != vcfgt_pkg::PH_STOP) begin
      if (vcfgt_pkg::is_digit(ch)) begin
        s.value  = (v > {3'b000, vcfgt_pkg::VALUE_CAP}) ? vcfgt_pkg::VALUE_CAP : v[8:0];
        s.digits = 1'b1;
        s.phase  = vcfgt_pkg::PH_DIGITS;
      end else if ((s_in.phase == vcfgt_pkg::PH_WS) && is_space(ch)) begin
        s.phase = vcfgt_pkg::PH_WS;
      end else if ((s_in.phase == vcfgt_pkg::PH_WS) &&
                   ((ch == vcfgt_pkg::CH_PLUS) || (ch == vcfgt_pkg::CH_MINUS))) begin
        s.neg   = s_in.neg | (ch == vcfgt_pkg::CH_MINUS);
        s.phase = vcfgt_pkg::PH_SIGN;
      end else begin
        s.phase = vcfgt_pkg::PH_STOP;
      end
    end
    return s;
  endfunction

  assign in_ch.ready = !snap_v_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_in;
  assign snap        = snap_r;
  assign snap_valid  = snap_v_r;

  always_comb begin
    clear_val               = '0;
    clear_val.side[0].phase = vcfgt_pkg::PH_WS;
    clear_val.side[1].phase = vcfgt_pkg::PH_WS;
  end

  always_comb begin
    live_nxt  = live_r;
    colon_nxt = colon_r;
    if (!colon_r) begin
      if (c == vcfgt_pkg::CH_COLON) begin
        colon_nxt = 1'b1;
      end else begin
        case (live_r.gt_length)
          3'd0:    live_nxt.head0     = c;
          3'd1:    live_nxt.head1_sep = vcfgt_pkg::is_sep(c);
          3'd2:    live_nxt.head2     = c;
          default: ;
        endcase
        if (live_r.gt_length != vcfgt_pkg::LEN_MAX) begin
          live_nxt.gt_length = live_r.gt_length + 3'd1;
        end
        if (vcfgt_pkg::is_sep(c)) begin
          if (live_r.sep_count != vcfgt_pkg::SEP_MAX) begin
            live_nxt.sep_count = live_r.sep_count + 2'd1;
          end
        end else if (!live_r.sep_count[1]) begin
          live_nxt.side[live_r.sep_count[0]] = feed(live_r.side[live_r.sep_count[0]], c);
        end
      end
    end
  end

  always_comb begin
    snap_v_nxt = snap_v_r;
    if (accept && in_ch.field_end) begin
      snap_v_nxt = 1'b1;
    end else if (out_free) begin
      snap_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= clear_val;
      colon_r  <= 1'b0;
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (accept) begin
        if (in_ch.field_end) begin
          live_r  <= clear_val;
          colon_r <= 1'b0;
        end else begin
          live_r  <= live_nxt;
          colon_r <= colon_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.field_end) begin
      snap_r <= live_nxt;
    end
  end

endmodule

### hw/rtl/vcfgt_finish.sv
module vcfgt_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  vcfgt_pkg::snap_t snap,
  input  logic             snap_valid,
  output logic             out_free,
  vcfgt_out_if.source      out_ch
);

  typedef enum logic [1:0] {
    JG_OK    = 2'd0,
    JG_NODIG = 2'd1,
    JG_NEG   = 2'd2,
    JG_BIG   = 2'd3
  } judge_t;

  logic               out_v_r;
  logic [1:0]         ploidy_r, ploidy_nxt;
  logic [7:0]         a_r, a_nxt, b_r, b_nxt;
  vcfgt_pkg::status_t st_r, st_nxt;
  judge_t             j0, j1;
  logic               m0, m1;
  logic               load;

  function automatic judge_t judge(vcfgt_pkg::side_t s);
    if (!s.digits) return JG_NODIG;
    if (s.neg && (s.value != 9'd0)) return JG_NEG;
    if (s.value > vcfgt_pkg::MAX_INDEX) return JG_BIG;
    return JG_OK;
  endfunction

  function automatic logic short_ok(logic [7:0] ch);
    return (ch == vcfgt_pkg::CH_DOT) || vcfgt_pkg::is_digit(ch);
  endfunction

  function automatic logic [7:0] short_code(logic [7:0] ch);
    return (ch == vcfgt_pkg::CH_DOT) ? 8'd0 : ({4'h0, ch[3:0]} + 8'd1);
  endfunction

  assign m0 = snap.side[0].dot;
  assign m1 = snap.side[1].dot;
  assign j0 = judge(snap.side[0]);
  assign j1 = judge(snap.side[1]);

  always_comb begin
    ploidy_nxt = 2'd0;
    a_nxt      = 8'd0;
    b_nxt      = 8'd0;
    st_nxt     = vcfgt_pkg::ST_OK;
    if (snap.gt_length == 3'd0) begin
      st_nxt = vcfgt_pkg::ST_EMPTY;
    end else if (snap.gt_length == 3'd1) begin
      if (short_ok(snap.head0)) begin
        ploidy_nxt = 2'd1;
        a_nxt      = short_code(snap.head0);
      end else begin
        st_nxt = vcfgt_pkg::ST_BAD_HAPLOID;
      end
    end else if ((snap.gt_length == 3'd3) && snap.head1_sep) begin
      if (!short_ok(snap.head0)) begin
        st_nxt = vcfgt_pkg::ST_BAD_FIRST;
      end else if (!short_ok(snap.head2)) begin
        st_nxt = vcfgt_pkg::ST_BAD_SECOND;
      end else begin
        ploidy_nxt = 2'd2;
        a_nxt      = short_code(snap.head0);
        b_nxt      = short_code(snap.head2);
      end
    end else if (snap.sep_count[1]) begin
      st_nxt = vcfgt_pkg::ST_POLYPLOID;
    end else if (snap.sep_count == 2'd0) begin
      case (j0)
        JG_NODIG: st_nxt = vcfgt_pkg::ST_NO_DIGITS;
        JG_NEG:   st_nxt = vcfgt_pkg::ST_NEG_HAPLOID;
        JG_BIG:   st_nxt = vcfgt_pkg::ST_TOO_LARGE;
        default: begin
          ploidy_nxt = 2'd1;
          a_nxt      = 8'(snap.side[0].value + 9'd1);
        end
      endcase
    end else if (!snap.side[0].start || !snap.side[1].start) begin
      st_nxt = vcfgt_pkg::ST_EDGE;
    end else if (!m0 && (j0 == JG_NODIG)) begin
      st_nxt = vcfgt_pkg::ST_NO_DIGITS;
    end else if (!m0 && (j0 == JG_NEG)) begin
      st_nxt = vcfgt_pkg::ST_NEG_FIRST;
    end else if (!m1 && (j1 == JG_NODIG)) begin
      st_nxt = vcfgt_pkg::ST_NO_DIGITS;
    end else if (!m1 && (j1 == JG_NEG)) begin
      st_nxt = vcfgt_pkg::ST_NEG_SECOND;
    end else if ((!m0 && (j0 == JG_BIG)) || (!m1 && (j1 == JG_BIG))) begin
      st_nxt = vcfgt_pkg::ST_TOO_LARGE;
    end else begin
      ploidy_nxt = 2'd2;
      a_nxt      = m0 ? 8'd0 : 8'(snap.side[0].value + 9'd1);
      b_nxt      = m1 ? 8'd0 : 8'(snap.side[1].value + 9'd1);
    end
  end

  assign out_free = !out_v_r || out_ch.ready;
  assign load     = snap_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ploidy_r <= ploidy_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      st_r     <= st_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.ploidy        = ploidy_r;
  assign out_ch.first_allele  = a_r;
  assign out_ch.second_allele = b_r;
  assign out_ch.status        = st_r;

endmodule

### hw/rtl/vcf_genotype_field_parser.sv
// Parses the GT part of one VCF sample column, fed one byte per request with
// field_end on the column's last byte; bytes from the first colon on are
// skipped. Throughput is one byte per cycle while in_ch.ready is high, with
// no gaps between columns. The result (ploidy, two allele codes as index
// plus one or 0 for missing, and a status) is registered on out_ch: the edge
// that accepts the field_end byte updates the byte scanner and snapshots its
// state, then the decoded result is registered. A stalled result blocks
// input only when a second finished column is already waiting behind it.
module vcf_genotype_field_parser (
  input logic         clk,
  input logic         rst_n,
  vcfgt_in_if.sink    in_ch,
  vcfgt_out_if.source out_ch
);

  vcfgt_pkg::snap_t snap;
  logic             snap_valid;
  logic             out_free;

  vcfgt_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_free   (out_free),
    .snap       (snap),
    .snap_valid (snap_valid)
  );

  vcfgt_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap       (snap),
    .snap_valid (snap_valid),
    .out_free   (out_free),
    .out_ch     (out_ch)
  );

endmodule

### hw/rtl/vcfgt_checker.sv
module vcfgt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] ploidy,
  input logic [7:0] first_allele,
  input logic [7:0] second_allele,
  input logic [3:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(ploidy) &&
      $stable(first_allele) && $stable(second_allele))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != 4'(vcfgt_pkg::ST_OK)) |->
      (ploidy == 2'd0) && (first_allele == 8'd0) && (second_allele == 8'd0))
    else $error("error result carries data");

  a_ok_ploidy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == 4'(vcfgt_pkg::ST_OK)) |-> (ploidy == 2'd1) || (ploidy == 2'd2))
    else $error("good result without ploidy");

  a_haploid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ploidy == 2'd1) |-> (second_allele == 8'd0))
    else $error("haploid result with second allele");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status <= 4'(vcfgt_pkg::ST_TOO_LARGE)))
    else $error("status out of range");

endmodule

bind vcf_genotype_field_parser vcfgt_checker u_vcfgt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .ploidy        (out_ch.ploidy),
  .first_allele  (out_ch.first_allele),
  .second_allele (out_ch.second_allele),
  .status        (out_ch.status)
);

### tb/sv/tb_vcf_genotype_field_parser.sv
module tb_vcf_genotype_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG  = 2000;
  localparam int N_BYTES   = 1800;
  localparam int TAIL_WAIT = 8;
  localparam int N_ROWS    = 26;

  typedef struct packed {
    logic [1:0]         ploidy;
    logic [7:0]         first;
    logic [7:0]         second;
    vcfgt_pkg::status_t status;
  } gt_call_t;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         pinned;
    gt_call_t   want;
  } gt_byte_t;

  typedef struct {
    string    text;
    bit       pinned;
    gt_call_t want;
  } gt_row_t;

  typedef enum int {SIDE_OK, SIDE_NO_DIGITS, SIDE_NEG, SIDE_BIG} side_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vcfgt_in_if  in_ch ();
  vcfgt_out_if out_ch ();

  vcf_genotype_field_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // genotype predictor state
  logic [2:0]       gt_len;
  bit               gt_colon;
  logic [1:0]       gt_seps;
  logic [7:0]       gt_head [3];
  vcfgt_pkg::side_t gt_side [2];

  gt_byte_t   request_q [$];
  gt_call_t   call_q [$];
  logic [7:0] column [$];
  gt_row_t    dir_rows [N_ROWS];

  gt_byte_t   cur;
  bit         emitted;
  gt_call_t   decoded;
  gt_call_t   want;
  int         gap_in;
  int         stall_out;
  int         idle;
  int         cyc;
  bit         calm;
  int         errors;

  function automatic bit is_num_char(logic [7:0] c);
    return c >= vcfgt_pkg::CH_ZERO && c <= vcfgt_pkg::CH_NINE;
  endfunction

  function automatic bit is_gt_sep(logic [7:0] c);
    return c == vcfgt_pkg::CH_SLASH || c == vcfgt_pkg::CH_PIPE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == vcfgt_pkg::CH_SPACE || (c >= vcfgt_pkg::CH_TAB && c <= vcfgt_pkg::CH_CR);
  endfunction

  function automatic bit is_allele_char(logic [7:0] c);
    return c == vcfgt_pkg::CH_DOT || is_num_char(c);
  endfunction

  function automatic logic [7:0] short_code(logic [7:0] c);
    return (c == vcfgt_pkg::CH_DOT) ? 8'd0 : c - vcfgt_pkg::CH_ZERO + 8'd1;
  endfunction

  function automatic gt_call_t call_of(logic [1:0] p, logic [7:0] a, logic [7:0] b,
                                       vcfgt_pkg::status_t s);
    gt_call_t r;
    r.ploidy = p;
    r.first  = a;
    r.second = b;
    r.status = s;
    return r;
  endfunction

  function automatic void gt_clear();
    gt_len   = '0;
    gt_colon = 1'b0;
    gt_seps  = '0;
    for (int k = 0; k < 3; k++) gt_head[k] = '0;
    for (int k = 0; k < 2; k++) begin
      gt_side[k]       = '0;
      gt_side[k].phase = vcfgt_pkg::PH_WS;
    end
  endfunction

  function automatic void side_feed(int k, logic [7:0] c);
    vcfgt_pkg::side_t s;
    int unsigned v;
    s = gt_side[k];
    if (!s.start) begin
      s.start = 1'b1;
      s.dot   = (c == vcfgt_pkg::CH_DOT);
    end else begin
      s.dot = 1'b0;
    end
    if (s.phase != vcfgt_pkg::PH_STOP) begin
      if (is_num_char(c)) begin
        v = 32'(s.value) * 32'd10 + 32'(c - vcfgt_pkg::CH_ZERO);
        s.value  = (v > 32'(vcfgt_pkg::VALUE_CAP)) ? vcfgt_pkg::VALUE_CAP : v[8:0];
        s.digits = 1'b1;
        s.phase  = vcfgt_pkg::PH_DIGITS;
      end else if (s.phase == vcfgt_pkg::PH_WS && is_blank(c)) begin
        s.phase = vcfgt_pkg::PH_WS;
      end else if (s.phase == vcfgt_pkg::PH_WS &&
                   (c == vcfgt_pkg::CH_PLUS || c == vcfgt_pkg::CH_MINUS)) begin
        if (c == vcfgt_pkg::CH_MINUS) s.neg = 1'b1;
        s.phase = vcfgt_pkg::PH_SIGN;
      end else begin
        s.phase = vcfgt_pkg::PH_STOP;
      end
    end
    gt_side[k] = s;
  endfunction

  function automatic side_verdict_t side_verdict(int k);
    if (!gt_side[k].digits) return SIDE_NO_DIGITS;
    if (gt_side[k].neg && gt_side[k].value != 0) return SIDE_NEG;
    if (gt_side[k].value > vcfgt_pkg::MAX_INDEX) return SIDE_BIG;
    return SIDE_OK;
  endfunction

  function automatic gt_call_t gt_decide();
    gt_call_t r;
    side_verdict_t j0;
    side_verdict_t j1;
    bit m0;
    bit m1;
    r = call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_OK);
    if (gt_len == 0) begin
      r.status = vcfgt_pkg::ST_EMPTY;
    end else if (gt_len == 1) begin
      if (is_allele_char(gt_head[0]))
        r = call_of(2'd1, short_code(gt_head[0]), 8'd0, vcfgt_pkg::ST_OK);
      else r.status = vcfgt_pkg::ST_BAD_HAPLOID;
    end else if (gt_len == 3 && is_gt_sep(gt_head[1])) begin
      if (!is_allele_char(gt_head[0])) r.status = vcfgt_pkg::ST_BAD_FIRST;
      else if (!is_allele_char(gt_head[2])) r.status = vcfgt_pkg::ST_BAD_SECOND;
      else r = call_of(2'd2, short_code(gt_head[0]), short_code(gt_head[2]),
                       vcfgt_pkg::ST_OK);
    end else if (gt_seps >= 2) begin
      r.status = vcfgt_pkg::ST_POLYPLOID;
    end else if (gt_seps == 0) begin
      j0 = side_verdict(0);
      case (j0)
        SIDE_NO_DIGITS: r.status = vcfgt_pkg::ST_NO_DIGITS;
        SIDE_NEG:       r.status = vcfgt_pkg::ST_NEG_HAPLOID;
        SIDE_BIG:       r.status = vcfgt_pkg::ST_TOO_LARGE;
        default:        r = call_of(2'd1, 8'(gt_side[0].value + 9'd1), 8'd0,
                                    vcfgt_pkg::ST_OK);
      endcase
    end else if (!gt_side[0].start || !gt_side[1].start) begin
      r.status = vcfgt_pkg::ST_EDGE;
    end else begin
      m0 = gt_side[0].dot;
      m1 = gt_side[1].dot;
      j0 = m0 ? SIDE_OK : side_verdict(0);
      j1 = m1 ? SIDE_OK : side_verdict(1);
      if (j0 == SIDE_NO_DIGITS) r.status = vcfgt_pkg::ST_NO_DIGITS;
      else if (j0 == SIDE_NEG) r.status = vcfgt_pkg::ST_NEG_FIRST;
      else if (j1 == SIDE_NO_DIGITS) r.status = vcfgt_pkg::ST_NO_DIGITS;
      else if (j1 == SIDE_NEG) r.status = vcfgt_pkg::ST_NEG_SECOND;
      else if (j0 == SIDE_BIG || j1 == SIDE_BIG) r.status = vcfgt_pkg::ST_TOO_LARGE;
      else r = call_of(2'd2, m0 ? 8'd0 : 8'(gt_side[0].value + 9'd1),
                       m1 ? 8'd0 : 8'(gt_side[1].value + 9'd1), vcfgt_pkg::ST_OK);
    end
    return r;
  endfunction

  function automatic void gt_take(logic [7:0] c, bit last, output bit done,
                                  output gt_call_t r);
    if (!gt_colon) begin
      if (c == vcfgt_pkg::CH_COLON) begin
        gt_colon = 1'b1;
      end else begin
        if (gt_len < 3) gt_head[gt_len] = c;
        if (gt_len < vcfgt_pkg::LEN_MAX) gt_len++;
        if (is_gt_sep(c)) begin
          if (gt_seps < vcfgt_pkg::SEP_MAX) gt_seps++;
        end else if (gt_seps < 2) begin
          side_feed(int'(gt_seps), c);
        end
      end
    end
    done = last;
    r = '0;
    if (last) begin
      r = gt_decide();
      gt_clear();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic put_byte(logic [7:0] b);
    column = {column, b};
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_num(int v);
    put_str($sformatf("%0d", v));
  endtask

  task automatic close_column(bit pinned, gt_call_t w);
    gt_byte_t b;
    for (int i = 0; i < column.size(); i++) begin
      b.ch     = column[i];
      b.last   = (i == column.size() - 1);
      b.pinned = pinned;
      b.want   = w;
      request_q = {request_q, b};
    end
    column.delete();
  endtask

  task automatic add_row(string s, bit pinned, gt_call_t w);
    put_str(s);
    close_column(pinned, w);
  endtask

  task automatic put_sep();
    put_byte($urandom_range(0, 1) ? vcfgt_pkg::CH_SLASH : vcfgt_pkg::CH_PIPE);
  endtask

  task automatic put_short_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) put_byte(8'($urandom_range(0, 255)));
    else if (r < 25) put_byte(vcfgt_pkg::CH_DOT);
    else put_byte(vcfgt_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_side();
    string junk;
    junk = " +-.0123456789ab\t\r|/";
    case ($urandom_range(0, 9))
      0: put_byte(vcfgt_pkg::CH_DOT);
      1, 2, 3, 4: put_num($urandom_range(0, 12));
      5: put_num($urandom_range(0, 400));
      6: begin
        repeat ($urandom_range(1, 2))
          put_byte($urandom_range(0, 5) == 0 ? vcfgt_pkg::CH_SPACE :
                   8'($urandom_range(9, 13)));
        if ($urandom_range(0, 1))
          put_byte($urandom_range(0, 1) ? vcfgt_pkg::CH_PLUS : vcfgt_pkg::CH_MINUS);
        put_num($urandom_range(0, 300));
      end
      7: begin
        put_byte(vcfgt_pkg::CH_MINUS);
        put_num($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 50));
      end
      8: begin
        put_num($urandom_range(0, 30));
        put_byte(junk[$urandom_range(0, 4)]);
      end
      default: repeat ($urandom_range(1, 3)) put_byte(junk[$urandom_range(0, junk.len() - 1)]);
    endcase
  endtask

  task automatic random_column();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      put_short_char();
      put_sep();
      put_short_char();
    end else if (r < 25) begin
      put_short_char();
    end else if (r < 55) begin
      put_side();
      put_sep();
      put_side();
    end else if (r < 65) begin
      put_side();
    end else if (r < 73) begin
      if ($urandom_range(0, 1)) put_sep();
      put_side();
      repeat ($urandom_range(0, 2)) begin
        put_sep();
        if ($urandom_range(0, 2)) put_side();
      end
      if ($urandom_range(0, 1)) put_sep();
    end else if (r < 85) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(vcfgt_pkg::CH_COLON);
    end
    if (r >= 85 || $urandom_range(0, 9) < 3) begin
      put_byte(vcfgt_pkg::CH_COLON);
      repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
    end
    close_column(1'b0, '0);
  endtask

  task automatic compare_field(string name, logic [7:0] w, logic [7:0] got);
    if (got !== w) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, w, got);
    end
  endtask

  // input side: advance the predictor on every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        gt_take(cur.ch, cur.last, emitted, decoded);
        if (emitted) call_q = {call_q, cur.pinned ? cur.want : decoded};
        if (gap_in == 0 && request_q.size() > 0) begin
          cur = request_q.pop_front();
          in_ch.char_in   <= cur.ch;
          in_ch.field_end <= cur.last;
          in_ch.valid     <= 1'b1;
          gap_in = calm ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end else if (!in_ch.valid) begin
        if (gap_in > 0) begin
          gap_in--;
        end else if (request_q.size() > 0) begin
          cur = request_q.pop_front();
          in_ch.char_in   <= cur.ch;
          in_ch.field_end <= cur.last;
          in_ch.valid     <= 1'b1;
          gap_in = calm ? 0 : pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (call_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, ploidy %0d first %0d second %0d status %0d",
                   $realtime, out_ch.ploidy, out_ch.first_allele, out_ch.second_allele,
                   out_ch.status);
        end else begin
          want = call_q.pop_front();
          compare_field("ploidy", 8'(want.ploidy), 8'(out_ch.ploidy));
          compare_field("first_allele", want.first, out_ch.first_allele);
          compare_field("second_allele", want.second, out_ch.second_allele);
          compare_field("status", 8'(want.status), 8'(out_ch.status));
        end
      end
      if (stall_out > 0) begin
        stall_out--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_out = calm ? 0 : pick_gap();
      end
    end
  end

  // alternate between stretches with and without idling
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle <= 0;
      end else if (idle >= WATCHDOG) begin
        $display("tb_vcf_genotype_field_parser: done, errors");
        $finish;
      end else begin
        idle <= idle + 1;
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.char_in    = '0;
    in_ch.field_end  = 1'b0;
    out_ch.ready     = 1'b0;
    gap_in    = 0;
    stall_out = 0;
    idle      = 0;
    cyc       = 0;
    calm      = 1'b0;
    errors    = 0;
    gt_clear();

    dir_rows = '{
      '{"0",        1'b1, call_of(2'd1, 8'd1, 8'd0, vcfgt_pkg::ST_OK)},
      '{".",        1'b1, call_of(2'd1, 8'd0, 8'd0, vcfgt_pkg::ST_OK)},
      '{"x",        1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_BAD_HAPLOID)},
      '{":",        1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_EMPTY)},
      '{"0/1",      1'b1, call_of(2'd2, 8'd1, 8'd2, vcfgt_pkg::ST_OK)},
      '{".|9",      1'b1, call_of(2'd2, 8'd0, 8'd10, vcfgt_pkg::ST_OK)},
      '{"a/1",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_BAD_FIRST)},
      '{"1|b",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_BAD_SECOND)},
      '{"///",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_BAD_FIRST)},
      '{"1/2/3",    1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_POLYPLOID)},
      '{"/12",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_EDGE)},
      '{"12|",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_EDGE)},
      '{"-5",       1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_NEG_HAPLOID)},
      '{"-3/1",     1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_NEG_FIRST)},
      '{"1/-3",     1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_NEG_SECOND)},
      '{"-0",       1'b1, call_of(2'd1, 8'd1, 8'd0, vcfgt_pkg::ST_OK)},
      '{"ab",       1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_NO_DIGITS)},
      '{"254",      1'b1, call_of(2'd1, 8'd255, 8'd0, vcfgt_pkg::ST_OK)},
      '{"255",      1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_TOO_LARGE)},
      '{"99999/1",  1'b1, call_of(2'd0, 8'd0, 8'd0, vcfgt_pkg::ST_TOO_LARGE)},
      '{"0254|254", 1'b1, call_of(2'd2, 8'd255, 8'd255, vcfgt_pkg::ST_OK)},
      '{" +7:GT:\377",  1'b0, '0},
      '{"..",           1'b0, '0},
      '{"12|.5",        1'b0, '0},
      '{"\t-0012/003x", 1'b0, '0},
      '{"-99999/4",     1'b0, '0}
    };

    foreach (dir_rows[i]) add_row(dir_rows[i].text, dir_rows[i].pinned, dir_rows[i].want);

    while (request_q.size() < N_BYTES) random_column();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (request_q.size() != 0 || in_ch.valid || call_q.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("tb_vcf_genotype_field_parser: done, clean");
    end else begin
      $display("tb_vcf_genotype_field_parser: done, errors");
    end
    $finish;
  end

endmodule
